>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_CLK(lbl, prop) `ASSERT_IMPL(lbl, clock, reset, prop)
`else
`define ASSERT_IMPL(lbl, clk, rst, prop)
`define ASSERT_CLK(lbl, prop)
`endif

`endif

>>> rtl/core/blpwm_pkg.sv
package blpwm_pkg;

   localparam int unsigned CsrIdxW = 3;

   localparam logic [CsrIdxW-1:0] CSR_PWM_PERIOD = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_RISE_MS    = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_FALL_MS    = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_REST_MS    = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_STEP_MS    = 3'd4;

   localparam logic [15:0] PWM_PERIOD_RST = 16'd5000;
   localparam logic [15:0] RISE_MS_RST    = 16'd950;
   localparam logic [15:0] FALL_MS_RST    = 16'd950;
   localparam logic [15:0] REST_MS_RST    = 16'd100;
   localparam logic [7:0]  STEP_MS_RST    = 8'd2;

   localparam logic [1:0] PHASE_RISE = 2'd0;
   localparam logic [1:0] PHASE_FALL = 2'd1;
   localparam logic [1:0] PHASE_REST = 2'd2;

   localparam logic [15:0] DUTY_MAX = 16'hFFFF;

   typedef struct packed {
      logic [15:0] pwm_period;
      logic [15:0] rise_ms;
      logic [15:0] fall_ms;
      logic [15:0] rest_ms;
      logic [7:0]  step_ms;
   } cfg_type;

endpackage

>>> rtl/core/blpwm_csr.sv
module blpwm_csr
   import blpwm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  logic [CsrIdxW-1:0] wr_index,
   input  logic [15:0]        wr_data,
   output cfg_type            cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            CSR_PWM_PERIOD: cfg_in.pwm_period = wr_data;
            CSR_RISE_MS:    cfg_in.rise_ms    = wr_data;
            CSR_FALL_MS:    cfg_in.fall_ms    = wr_data;
            CSR_REST_MS:    cfg_in.rest_ms    = wr_data;
            CSR_STEP_MS:    cfg_in.step_ms    = wr_data[7:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pwm_period <= PWM_PERIOD_RST;
         cfg_ff.rise_ms    <= RISE_MS_RST;
         cfg_ff.fall_ms    <= FALL_MS_RST;
         cfg_ff.rest_ms    <= REST_MS_RST;
         cfg_ff.step_ms    <= STEP_MS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/core/blpwm_seq.sv
module blpwm_seq
   import blpwm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic [31:0] now_ms,
   input  cfg_type     cfg,
   output logic [15:0] duty_next,
   output logic [15:0] duty_cur
);

   logic [1:0]  phase_ff,      phase_in;
   logic [31:0] phase_mark_ff, phase_mark_in;
   logic [31:0] step_mark_ff,  step_mark_in;
   logic [15:0] duty_ff,       duty_in;

   logic [31:0] step_elapsed;
   logic [31:0] phase_elapsed;
   logic        step_due;
   logic [15:0] phase_len;
   logic [1:0]  phase_after;

   assign step_elapsed  = now_ms - step_mark_ff;
   assign phase_elapsed = now_ms - phase_mark_ff;
   assign step_due      = step_elapsed > {24'd0, cfg.step_ms};

   // shadow compare always tracks the next duty; the PWM loads it at the start of each period
   always_comb begin
      duty_in      = duty_ff;
      step_mark_in = step_mark_ff;
      case (phase_ff)
         PHASE_RISE: begin
            phase_len   = cfg.rise_ms;
            phase_after = PHASE_FALL;
            if (step_due) begin
               step_mark_in = now_ms;
               if (duty_ff != DUTY_MAX) duty_in = duty_ff + 16'd1;
            end
         end
         PHASE_FALL: begin
            phase_len   = cfg.fall_ms;
            phase_after = PHASE_REST;
            if (step_due) begin
               step_mark_in = now_ms;
               if (duty_ff != 16'd0) duty_in = duty_ff - 16'd1;
            end
         end
         default: begin
            phase_len   = cfg.rest_ms;
            phase_after = PHASE_RISE;
         end
      endcase
      phase_in      = phase_ff;
      phase_mark_in = phase_mark_ff;
      if (phase_elapsed >= {16'd0, phase_len}) begin
         phase_in      = phase_after;
         phase_mark_in = now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PHASE_RISE;
         phase_mark_ff <= 32'd0;
         step_mark_ff  <= 32'd0;
         duty_ff       <= 16'd0;
      end else if (advance) begin
         phase_ff      <= phase_in;
         phase_mark_ff <= phase_mark_in;
         step_mark_ff  <= step_mark_in;
         duty_ff       <= duty_in;
      end
   end

   assign duty_next = duty_in;
   assign duty_cur  = duty_ff;

endmodule

>>> rtl/core/blpwm_pwm.sv
module blpwm_pwm
   import blpwm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic [15:0] period,
   input  logic [15:0] shadow,
   output logic        led_next
);

   logic [15:0] count_ff,  count_in;
   logic [15:0] active_ff, active_in;
   logic        led_ff,    led_in;
   logic [16:0] count_inc;

   assign count_inc = {1'b0, count_ff} + 17'd1;

   always_comb begin
      led_in    = led_ff;
      active_in = active_ff;
      count_in  = count_inc[15:0];
      if (count_inc > {1'b0, period}) begin
         count_in  = 16'd0;
         active_in = shadow;
         led_in    = (shadow != 16'd0);
      end
      if (count_in == active_in) led_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 16'd0;
         active_ff <= 16'd0;
         led_ff    <= 1'b0;
      end else if (advance) begin
         count_ff  <= count_in;
         active_ff <= active_in;
         led_ff    <= led_in;
      end
   end

   assign led_next = led_in;

endmodule

>>> rtl/core/breathing_led_pwm.sv
// A request passes through the input register and then the result register to rsp_valid.
// Throughput: one transaction per cycle; ready stays high while the result register
// drains or is empty.
// Reset: synchronous, active high; clears the pipeline, ramp state and PWM counter,
// and loads the register defaults.
`include "assert_macros.svh"

module breathing_led_pwm
   import blpwm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [31:0]        req_now_ms,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_led_on,
   output logic [15:0]        rsp_duty_now,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [15:0]        csr_wdata
);

   cfg_type     cfg;
   logic        in_valid_ff,  in_valid_in;
   logic [31:0] in_now_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_led_ff;
   logic [15:0] rsp_duty_ff;
   logic        advance;
   logic        req_take;
   logic [15:0] duty_next;
   logic [15:0] duty_cur;
   logic        led_next;

   assign csr_ready = 1'b1;
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   blpwm_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   blpwm_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .now_ms    (in_now_ff),
      .cfg       (cfg),
      .duty_next (duty_next),
      .duty_cur  (duty_cur)
   );

   blpwm_pwm u_pwm (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .period   (cfg.pwm_period),
      .shadow   (duty_next),
      .led_next (led_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) in_now_ff <= req_now_ms;
      if (advance) begin
         rsp_led_ff  <= led_next;
         rsp_duty_ff <= duty_next;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_led_on   = rsp_led_ff;
   assign rsp_duty_now = rsp_duty_ff;

   `ASSERT_CLK(a_no_overwrite, rsp_valid_ff && !rsp_ready |-> !advance)
   `ASSERT_CLK(a_advance_fills, advance |=> rsp_valid_ff)
   `ASSERT_CLK(a_duty_moves_by_one, advance |=> (rsp_duty_now - $past(duty_cur) + 16'd1) <= 16'd2)

endmodule

>>> tb/tb_breathing_led_pwm.sv
`timescale 1ns / 1ps

module tb_breathing_led_pwm;
   import blpwm_pkg::*;

   localparam logic [CsrIdxW-1:0] CSR_HOLE_5 = 3'd5;
   localparam logic [CsrIdxW-1:0] CSR_HOLE_6 = 3'd6;
   localparam logic [CsrIdxW-1:0] CSR_HOLE_7 = 3'd7;

   typedef struct packed {
      logic        led;
      logic [15:0] duty;
   } glow_type;

   typedef enum logic {ROW_TICK, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type       kind;
      logic [CsrIdxW-1:0] idx;
      logic [31:0]        val;
      logic               typed;
      logic               led;
      logic [15:0]        duty;
   } plan_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [31:0]        req_now_ms = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_led_on;
   logic [15:0]        rsp_duty_now;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CsrIdxW-1:0] csr_index = '0;
   logic [15:0]        csr_wdata = '0;

   breathing_led_pwm DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_now_ms(req_now_ms),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_led_on(rsp_led_on),
      .rsp_duty_now(rsp_duty_now),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // breathing ramp predictor state
   cfg_type     cfg_q = '{PWM_PERIOD_RST, RISE_MS_RST, FALL_MS_RST, REST_MS_RST, STEP_MS_RST};
   logic [1:0]  phase_q = PHASE_RISE;
   logic [31:0] phase_mark = '0;
   logic [31:0] step_mark = '0;
   logic [15:0] duty_q = '0;
   logic [15:0] pwm_cnt = '0;
   logic [15:0] cmp_live = '0;
   logic [15:0] cmp_shadow = '0;
   logic        led_q = 1'b0;

   glow_type     glow_q[$];
   plan_row_type plan [0:24];
   logic [31:0]  ms_now = '0;
   int           burst_left = 0;
   int           ready_hold = 0;
   bit           steady = 1'b0;
   bit           ticking = 1'b0;
   bit           csr_held = 1'b0;
   int           ticks = 0;
   int           checked = 0;
   int           writes = 0;
   int           fails = 0;

   function automatic void ramp(input logic [31:0] now, input bit up);
      logic [31:0] elapsed;
      elapsed = now - step_mark;
      if (elapsed > {24'd0, cfg_q.step_ms}) begin
         step_mark = now;
         if (up) begin
            if (duty_q != DUTY_MAX) duty_q = duty_q + 16'd1;
         end else begin
            if (duty_q != 16'd0) duty_q = duty_q - 16'd1;
         end
         cmp_shadow = duty_q;
      end
   endfunction

   function automatic void phase_end(input logic [31:0] now, input logic [15:0] len,
                                     input logic [1:0] nxt_phase);
      logic [31:0] elapsed;
      elapsed = now - phase_mark;
      if (elapsed >= {16'd0, len}) begin
         phase_mark = now;
         phase_q = nxt_phase;
      end
   endfunction

   function automatic glow_type breath_tick(input logic [31:0] now);
      glow_type    g;
      logic [16:0] nxt;
      case (phase_q)
         PHASE_RISE: begin
            ramp(now, 1'b1);
            phase_end(now, cfg_q.rise_ms, PHASE_FALL);
         end
         PHASE_FALL: begin
            ramp(now, 1'b0);
            phase_end(now, cfg_q.fall_ms, PHASE_REST);
         end
         default: begin
            phase_end(now, cfg_q.rest_ms, PHASE_RISE);
         end
      endcase
      nxt = {1'b0, pwm_cnt} + 17'd1;
      if (nxt > {1'b0, cfg_q.pwm_period}) begin
         nxt = '0;
         cmp_live = cmp_shadow;
         led_q = (cmp_live != 16'd0);
      end
      pwm_cnt = nxt[15:0];
      if (pwm_cnt == cmp_live) led_q = 1'b0;
      g.led = led_q;
      g.duty = duty_q;
      return g;
   endfunction

   function automatic logic [15:0] pick_len();
      if ($urandom_range(0, 9) == 0) return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      return 16'($urandom_range(1, 60));
   endfunction

   task automatic put_tick(input logic [31:0] now, input bit typed, input glow_type given);
      glow_type calc;
      int       gap;
      if (csr_held) begin
         csr_valid <= 1'b0;
         csr_held = 1'b0;
      end
      if (burst_left == 0) begin
         burst_left = steady ? 100000 : $urandom_range(1, 24);
         gap = steady ? 0 : $urandom_range(0, 4);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_now_ms <= now;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      calc = breath_tick(now);
      glow_q.push_back(typed ? given : calc);
      ticking = 1'b1;
      ticks++;
   endtask

   // stop sending and let every outstanding transaction come back
   task automatic go_idle();
      if (ticking) begin
         req_valid <= 1'b0;
         ticking = 1'b0;
         burst_left = 0;
         while (glow_q.size() != 0) @(posedge clock);
         repeat (4) @(posedge clock);
      end
   endtask

   task automatic csr_put(input logic [CsrIdxW-1:0] idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      csr_held = 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_PWM_PERIOD: cfg_q.pwm_period = data;
         CSR_RISE_MS:    cfg_q.rise_ms = data;
         CSR_FALL_MS:    cfg_q.fall_ms = data;
         CSR_REST_MS:    cfg_q.rest_ms = data;
         CSR_STEP_MS:    cfg_q.step_ms = data[7:0];
         default: ;
      endcase
      writes++;
   endtask

   task automatic load_config(input logic [15:0] period, input logic [15:0] rise,
                              input logic [15:0] fall, input logic [15:0] rest,
                              input logic [7:0] step);
      logic [7:0] junk;
      junk = 8'($urandom_range(0, 255));
      go_idle();
      csr_put(CSR_PWM_PERIOD, period);
      csr_put(CSR_RISE_MS, rise);
      csr_put(CSR_FALL_MS, fall);
      csr_put(CSR_REST_MS, rest);
      csr_put(CSR_STEP_MS, {junk, step});
      if ($urandom_range(0, 2) == 0) begin
         case ($urandom_range(0, 2))
            0: csr_put(CSR_HOLE_5, 16'($urandom));
            1: csr_put(CSR_HOLE_6, 16'($urandom));
            default: csr_put(CSR_HOLE_7, 16'($urandom));
         endcase
      end
   endtask

   // mostly monotonic time with random jumps and small steps back
   task automatic run_random(input int n);
      int r;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(0, 99);
         if (r < 85) ms_now = ms_now + $urandom_range(0, cfg_q.step_ms + 3);
         else if (r < 93) ms_now = $urandom;
         else ms_now = ms_now - $urandom_range(1, 50);
         put_tick(ms_now, 1'b0, '0);
      end
   endtask

   task automatic take_glow();
      glow_type want;
      if (glow_q.size() == 0) begin
         $error("unexpected transaction: led_on=%0d duty_now=%0d", rsp_led_on, rsp_duty_now);
         fails++;
      end else begin
         want = glow_q.pop_front();
         if (rsp_led_on !== want.led) begin
            $error("led_on: expected %0d, actual %0d", want.led, rsp_led_on);
            fails++;
         end
         if (rsp_duty_now !== want.duty) begin
            $error("duty_now: expected %0d, actual %0d", want.duty, rsp_duty_now);
            fails++;
         end
         checked++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) take_glow();
      if (steady) begin
         rsp_ready <= 1'b1;
      end else if (ready_hold != 0) begin
         ready_hold = ready_hold - 1;
      end else begin
         rsp_ready <= !rsp_ready;
         ready_hold = rsp_ready ? $urandom_range(0, 2) : $urandom_range(0, 14);
      end
   end

   initial begin
      plan = '{
         '{ROW_TICK, '0,             32'h0000_0000, 1'b1, 1'b0, 16'd0},
         '{ROW_TICK, '0,             32'h0000_0003, 1'b1, 1'b0, 16'd1},
         '{ROW_TICK, '0,             32'hFFFF_FFFF, 1'b1, 1'b0, 16'd2},
         '{ROW_TICK, '0,             32'h0000_0002, 1'b1, 1'b0, 16'd1},
         '{ROW_TICK, '0,             32'h0000_0006, 1'b1, 1'b0, 16'd0},
         '{ROW_TICK, '0,             32'h0000_000A, 1'b1, 1'b0, 16'd0},
         '{ROW_CSR,  CSR_PWM_PERIOD, 32'h0000_0000, 1'b0, 1'b0, 16'd0},
         '{ROW_CSR,  CSR_STEP_MS,    32'h0000_AB00, 1'b0, 1'b0, 16'd0},
         '{ROW_CSR,  CSR_HOLE_5,     32'h0000_FFFF, 1'b0, 1'b0, 16'd0},
         '{ROW_CSR,  CSR_HOLE_7,     32'h0000_1234, 1'b0, 1'b0, 16'd0},
         '{ROW_TICK, '0,             32'h0000_000B, 1'b1, 1'b0, 16'd0},
         '{ROW_CSR,  CSR_FALL_MS,    32'h0000_0000, 1'b0, 1'b0, 16'd0},
         '{ROW_TICK, '0,             32'h0000_000C, 1'b1, 1'b0, 16'd0},
         '{ROW_CSR,  CSR_REST_MS,    32'h0000_0000, 1'b0, 1'b0, 16'd0},
         '{ROW_TICK, '0,             32'h0000_000C, 1'b1, 1'b0, 16'd0},
         '{ROW_CSR,  CSR_RISE_MS,    32'h0000_FFFF, 1'b0, 1'b0, 16'd0},
         '{ROW_TICK, '0,             32'h0000_0014, 1'b1, 1'b1, 16'd1},
         '{ROW_TICK, '0,             32'h8000_0000, 1'b0, 1'b0, 16'd0},
         '{ROW_TICK, '0,             32'h7FFF_FFFF, 1'b0, 1'b0, 16'd0},
         '{ROW_CSR,  CSR_PWM_PERIOD, 32'h0000_0002, 1'b0, 1'b0, 16'd0},
         '{ROW_TICK, '0,             32'h5555_5555, 1'b0, 1'b0, 16'd0},
         '{ROW_TICK, '0,             32'hAAAA_AAAA, 1'b0, 1'b0, 16'd0},
         '{ROW_TICK, '0,             32'hAAAA_AAAB, 1'b0, 1'b0, 16'd0},
         '{ROW_CSR,  CSR_HOLE_6,     32'h0000_0000, 1'b0, 1'b0, 16'd0},
         '{ROW_TICK, '0,             32'hAAAA_AAAC, 1'b0, 1'b0, 16'd0}
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            go_idle();
            csr_put(plan[i].idx, plan[i].val[15:0]);
         end else begin
            put_tick(plan[i].val, plan[i].typed, {plan[i].led, plan[i].duty});
         end
      end
      ms_now = 32'hAAAA_AAAC;

      for (int p = 0; p < 6; p++) begin
         logic [15:0] period;
         logic [7:0]  step;
         case ($urandom_range(0, 5))
            0: period = 16'h0000;
            1: period = 16'hFFFF;
            default: period = 16'($urandom_range(1, 12));
         endcase
         step = ($urandom_range(0, 9) == 0) ? 8'hFF : 8'($urandom_range(0, 4));
         load_config(period, pick_len(), pick_len(), pick_len(), step);
         steady = (p == 2);
         run_random(55);
      end
      steady = 1'b0;

      // duty far above a short period: LED held on
      load_config(16'd3, 16'd40, 16'd40, 16'd5, 8'd0);
      for (int k = 0; k < 60; k++) begin
         ms_now = ms_now + $urandom_range(0, 2);
         put_tick(ms_now, 1'b0, '0);
      end

      req_valid <= 1'b0;
      while (glow_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("covered %0d ticks, %0d transactions checked, %0d register writes", ticks,
               checked, writes);
      $display("incl. duty floor, time wrap, zero and full-scale lengths, unmapped CSRs");
      if (fails == 0) begin
         $display("tb_breathing_led_pwm: PASS");
      end else begin
         $display("tb_breathing_led_pwm: FAIL");
      end
      $finish;
   end

   initial begin
      #60_000_000;
      $display("tb_breathing_led_pwm: FAIL");
      $finish;
   end

endmodule
